[rtl/vnq_pkg.sv]
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps

package vnq_pkg;

   localparam int IN_WIDTH           = 16;
   localparam int OUT_WIDTH          = 16;
   localparam int FRAC_BITS_DEFAULT  = 14;
   localparam int SQ_WIDTH           = 2 * IN_WIDTH;
   // magnitude, square and sum/shift stages ahead of the cell chain
   localparam int FRONT_STAGES       = 3;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] vec_x;
      logic signed [IN_WIDTH-1:0] vec_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] sine_q14;
      logic signed [OUT_WIDTH-1:0] cosine_q14;
   } rsp_type;

endpackage

[rtl/vnq_front.sv]
// Front stages: component magnitudes, squares, squared length and scaled residues.
`timescale 1ns / 1ps

module vnq_front import vnq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int RES_WIDTH = 2 * IN_WIDTH + 2 * FRAC_BITS + 2
) (
   input  logic                    clock,
   input  logic [FRONT_STAGES-1:0] load,
   input  req_type                 req_data,
   output logic [SQ_WIDTH-1:0]     sq_o,
   output logic [RES_WIDTH-1:0]    res_x_o,
   output logic [RES_WIDTH-1:0]    res_y_o,
   output logic                    neg_x_o,
   output logic                    neg_y_o
);

   logic [IN_WIDTH-1:0] raw_x;
   logic [IN_WIDTH-1:0] raw_y;
   logic [IN_WIDTH-1:0] mag_x_in;
   logic [IN_WIDTH-1:0] mag_y_in;

   logic [IN_WIDTH-1:0] mag_x_ff;
   logic [IN_WIDTH-1:0] mag_y_ff;
   logic                neg_a_x_ff;
   logic                neg_a_y_ff;
   logic [SQ_WIDTH-1:0] sqr_x_ff;
   logic [SQ_WIDTH-1:0] sqr_y_ff;
   logic                neg_b_x_ff;
   logic                neg_b_y_ff;
   logic [SQ_WIDTH-1:0] sq_ff;
   logic [RES_WIDTH-1:0] res_x_ff;
   logic [RES_WIDTH-1:0] res_y_ff;
   logic                neg_c_x_ff;
   logic                neg_c_y_ff;

   assign raw_x = req_data.vec_x;
   assign raw_y = req_data.vec_y;

   // most negative input maps to 2^(IN_WIDTH-1), still fits unsigned
   assign mag_x_in = raw_x[IN_WIDTH-1] ? (~raw_x + 1'b1) : raw_x;
   assign mag_y_in = raw_y[IN_WIDTH-1] ? (~raw_y + 1'b1) : raw_y;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         mag_x_ff   <= mag_x_in;
         mag_y_ff   <= mag_y_in;
         neg_a_x_ff <= raw_x[IN_WIDTH-1];
         neg_a_y_ff <= raw_y[IN_WIDTH-1];
      end
      if (load[1]) begin
         sqr_x_ff   <= SQ_WIDTH'(mag_x_ff) * SQ_WIDTH'(mag_x_ff);
         sqr_y_ff   <= SQ_WIDTH'(mag_y_ff) * SQ_WIDTH'(mag_y_ff);
         neg_b_x_ff <= neg_a_x_ff;
         neg_b_y_ff <= neg_a_y_ff;
      end
      if (load[2]) begin
         sq_ff      <= sqr_x_ff + sqr_y_ff;
         res_x_ff   <= RES_WIDTH'(sqr_x_ff) << (2 * FRAC_BITS);
         res_y_ff   <= RES_WIDTH'(sqr_y_ff) << (2 * FRAC_BITS);
         neg_c_x_ff <= neg_b_x_ff;
         neg_c_y_ff <= neg_b_y_ff;
      end
   end

   assign sq_o    = sq_ff;
   assign res_x_o = res_x_ff;
   assign res_y_o = res_y_ff;
   assign neg_x_o = neg_c_x_ff;
   assign neg_y_o = neg_c_y_ff;

endmodule

[rtl/vnq_cell.sv]
// One quotient bit: trial (q + 2^BIT)^2 * sq against the running residue.
`timescale 1ns / 1ps

module vnq_cell import vnq_pkg::*; #(
   parameter int BIT        = 0,
   parameter int RES_WIDTH  = 64,
   parameter int PROD_WIDTH = 48,
   parameter int QUO_WIDTH  = 15
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [SQ_WIDTH-1:0]   sq_i,
   input  logic [RES_WIDTH-1:0]  res_i,
   input  logic [PROD_WIDTH-1:0] prod_i,
   input  logic [QUO_WIDTH-1:0]  quo_i,
   input  logic                  neg_i,
   output logic [SQ_WIDTH-1:0]   sq_o,
   output logic [RES_WIDTH-1:0]  res_o,
   output logic [PROD_WIDTH-1:0] prod_o,
   output logic [QUO_WIDTH-1:0]  quo_o,
   output logic                  neg_o
);

   logic [RES_WIDTH-1:0]  trial;
   logic                  take;

   logic [SQ_WIDTH-1:0]   sq_ff;
   logic [RES_WIDTH-1:0]  res_ff;
   logic [PROD_WIDTH-1:0] prod_ff;
   logic [QUO_WIDTH-1:0]  quo_ff;
   logic                  neg_ff;

   // res = mag^2 * 2^2F - q^2 * sq, prod = q * sq
   // increment of q^2*sq for bit b: 2*b*prod + b^2*sq
   assign trial = (RES_WIDTH'(prod_i) << (BIT + 1)) + (RES_WIDTH'(sq_i) << (2 * BIT));
   // zero vector stays at zero
   assign take  = (sq_i != '0) && (trial <= res_i);

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff  <= sq_i;
         neg_ff <= neg_i;
         if (take) begin
            res_ff  <= res_i - trial;
            prod_ff <= prod_i + (PROD_WIDTH'(sq_i) << BIT);
            quo_ff  <= quo_i | (QUO_WIDTH'(1) << BIT);
         end else begin
            res_ff  <= res_i;
            prod_ff <= prod_i;
            quo_ff  <= quo_i;
         end
      end
   end

   assign sq_o   = sq_ff;
   assign res_o  = res_ff;
   assign prod_o = prod_ff;
   assign quo_o  = quo_ff;
   assign neg_o  = neg_ff;

endmodule

[rtl/vnq_out.sv]
// Output stage: applies the component sign, saturates +2.0 at 14 fraction bits.
`timescale 1ns / 1ps

module vnq_out import vnq_pkg::*; #(
   parameter int QUO_WIDTH = 15
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [QUO_WIDTH-1:0]        quo_i,
   input  logic                        neg_i,
   output logic signed [OUT_WIDTH-1:0] value_o
);

   localparam logic [OUT_WIDTH:0] POS_MAX = (OUT_WIDTH + 1)'((1 << (OUT_WIDTH - 1)) - 1);

   logic [OUT_WIDTH:0]   mag;
   logic [OUT_WIDTH:0]   neg_mag;
   logic [OUT_WIDTH-1:0] value_in;
   logic [OUT_WIDTH-1:0] value_ff;

   assign mag     = (OUT_WIDTH + 1)'(quo_i);
   assign neg_mag = ~mag + 1'b1;

   always_comb begin
      priority if (neg_i) begin
         value_in = neg_mag[OUT_WIDTH-1:0];
      end else if (mag > POS_MAX) begin
         value_in = POS_MAX[OUT_WIDTH-1:0];
      end else begin
         value_in = mag[OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
      end
   end

   assign value_o = value_ff;

endmodule

[rtl/vector_normalize_q14_core.sv]
// Vector normalizer top level: (x, y) to x/|v| and y/|v| in Q format, truncated.
// Results carry FRAC_BITS fraction bits, 14 by default. Takes one vector per cycle
// when the result side keeps up. Three front stages form the magnitudes, squares
// and squared length; then a chain of FRAC_BITS + 1 cells per component settles
// one quotient bit per cycle when not stalled, most significant first, with
// shifts and adds only; a last register applies the sign. Every stage holds its
// own valid bit and bubbles close up, so input is taken while a result waits as
// long as some stage is empty. A zero vector gives 0 and 0.
`timescale 1ns / 1ps

module vector_normalize_q14_core import vnq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CELLS      = FRAC_BITS + 1;
   localparam int STAGES     = FRONT_STAGES + CELLS + 1;
   localparam int RES_WIDTH  = 2 * IN_WIDTH + 2 * FRAC_BITS + 2;
   localparam int PROD_WIDTH = 2 * IN_WIDTH + FRAC_BITS + 1;
   localparam int QUO_WIDTH  = FRAC_BITS + 1;
   localparam int LANES      = 2;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] load;
   logic [STAGES:0]   rdy;

   logic [SQ_WIDTH-1:0]  front_sq;
   logic [RES_WIDTH-1:0] front_res_x;
   logic [RES_WIDTH-1:0] front_res_y;
   logic                 front_neg_x;
   logic                 front_neg_y;

   logic [SQ_WIDTH-1:0]   sq_c   [LANES][CELLS+1];
   logic [RES_WIDTH-1:0]  res_c  [LANES][CELLS+1];
   logic [PROD_WIDTH-1:0] prod_c [LANES][CELLS+1];
   logic [QUO_WIDTH-1:0]  quo_c  [LANES][CELLS+1];
   logic                  neg_c  [LANES][CELLS+1];

   logic signed [OUT_WIDTH-1:0] out_val [LANES];

   // a stage may load when it is empty or its content moves on this cycle
   always_comb begin
      rdy[STAGES] = rsp_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      load      = rdy[STAGES-1:0];
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[STAGES-1];

   vnq_front #(
      .FRAC_BITS (FRAC_BITS),
      .RES_WIDTH (RES_WIDTH)
   ) u_front (
      .clock    (clock),
      .load     (load[FRONT_STAGES-1:0]),
      .req_data (req_data),
      .sq_o     (front_sq),
      .res_x_o  (front_res_x),
      .res_y_o  (front_res_y),
      .neg_x_o  (front_neg_x),
      .neg_y_o  (front_neg_y)
   );

   assign sq_c[0][0]   = front_sq;
   assign sq_c[1][0]   = front_sq;
   assign res_c[0][0]  = front_res_x;
   assign res_c[1][0]  = front_res_y;
   assign neg_c[0][0]  = front_neg_x;
   assign neg_c[1][0]  = front_neg_y;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign prod_c[l][0] = '0;
      assign quo_c[l][0]  = '0;

      for (genvar c = 0; c < CELLS; c++) begin : g_cell
         vnq_cell #(
            .BIT        (FRAC_BITS - c),
            .RES_WIDTH  (RES_WIDTH),
            .PROD_WIDTH (PROD_WIDTH),
            .QUO_WIDTH  (QUO_WIDTH)
         ) u_cell (
            .clock  (clock),
            .load   (load[FRONT_STAGES+c]),
            .sq_i   (sq_c[l][c]),
            .res_i  (res_c[l][c]),
            .prod_i (prod_c[l][c]),
            .quo_i  (quo_c[l][c]),
            .neg_i  (neg_c[l][c]),
            .sq_o   (sq_c[l][c+1]),
            .res_o  (res_c[l][c+1]),
            .prod_o (prod_c[l][c+1]),
            .quo_o  (quo_c[l][c+1]),
            .neg_o  (neg_c[l][c+1])
         );
      end

      vnq_out #(
         .QUO_WIDTH (QUO_WIDTH)
      ) u_out (
         .clock   (clock),
         .load    (load[STAGES-1]),
         .quo_i   (quo_c[l][CELLS]),
         .neg_i   (neg_c[l][CELLS]),
         .value_o (out_val[l])
      );
   end

   assign rsp_data.sine_q14   = out_val[0];
   assign rsp_data.cosine_q14 = out_val[1];

endmodule

[rtl/vnq_checker.sv]
// Port-level checks for the vector normalizer, bound to the top level.
`timescale 1ns / 1ps

module vnq_checker import vnq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic signed [2*OUT_WIDTH:0] UNIT_SQ = (2 * OUT_WIDTH + 1)'(1) << (2 * FRAC_BITS);

   logic signed [2*OUT_WIDTH:0] sine_ext;
   logic signed [2*OUT_WIDTH:0] cosine_ext;
   logic signed [2*OUT_WIDTH:0] norm_sq;

   assign sine_ext   = (2 * OUT_WIDTH + 1)'(rsp_data.sine_q14);
   assign cosine_ext = (2 * OUT_WIDTH + 1)'(rsp_data.cosine_q14);
   assign norm_sq    = sine_ext * sine_ext + cosine_ext * cosine_ext;

   // input side only stalls when every stage is full and the result is held
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low with a free stage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // truncated components never exceed the unit circle
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (norm_sq <= UNIT_SQ))
      else $error("result outside unit circle");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind vector_normalize_q14_core vnq_checker #(.FRAC_BITS(FRAC_BITS)) u_vnq_checker (.*);
